[rtl/core/nsrb_pkg.sv]
// ----------------------------------------------------------------------------
// nsrb_pkg
// Types and constants shared by the SNTP server reply builder.
// ----------------------------------------------------------------------------
package nsrb_pkg;

    localparam logic [31:0] UNIX_TO_NTP_SECONDS = 32'd2208988800;
    localparam logic [2:0]  MODE_CLIENT         = 3'd3;
    localparam logic [2:0]  MODE_SERVER         = 3'd4;
    localparam logic [2:0]  VERSION_MIN_OK      = 3'd3;
    localparam int          HASH_BITS           = 11;
    localparam int          OFFSET_BITS         = 21;

    localparam logic [21:0] RST_MAX_OFFSET      = 22'd600;
    localparam logic        RST_OBFUSCATE       = 1'b1;

    typedef enum logic [1:0] {
        ST_REPLY       = 2'd0,
        ST_BAD_VERSION = 2'd1,
        ST_NOT_CLIENT  = 2'd2
    } t_status;

    typedef enum logic {
        REG_MAX_OFFSET = 1'b0,
        REG_OBFUSCATE  = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] max_offset;
        logic                   obfuscate_enable;
    } t_cfg;

    typedef struct packed {
        logic [19:0] now_microseconds;
        logic [31:0] now_seconds;
        logic [31:0] client_address;
        logic [63:0] request_transmit_ts;
        logic [7:0]  request_flags;
    } t_request;

    typedef struct packed {
        t_status                status;
        logic [OFFSET_BITS-1:0] applied_offset;
        logic [63:0]            reply_ts;
        logic [63:0]            origin_ts;
        logic [7:0]             reply_flags;
    } t_reply;

endpackage

[rtl/core/ntp_server_reply_builder_unit.sv]
// ----------------------------------------------------------------------------
// ntp_server_reply_builder_unit
// SNTP server reply builder with per-client time obfuscation.
// ----------------------------------------------------------------------------
// Accepts one request transfer every clock cycle unless backpressure stalls it,
// and returns exactly one result per request, in order. The
// request lands in an input register; one pass of logic (address hash, a 21x11
// multiply, the microsecond-to-fraction conversion and the seconds adder) then
// fills the output register. Backpressure on the master side stalls both
// stages in place. Registers: max_offset at byte address 0, obfuscate_enable
// at byte address 4; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module ntp_server_reply_builder_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // request: flags[7:0], transmit_ts[71:8], client_address[103:72],
    // now_seconds[135:104], now_microseconds[155:136], zero fill[159:156]
    input  logic [159:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // result: reply_flags[7:0], origin_ts[71:8], reply_ts[135:72],
    // applied_offset[156:136], zero fill[159:157]
    output logic [159:0] m_axis_tdata,
    // result: status[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import nsrb_pkg::*;

    t_cfg     w_cfg;
    t_request w_req_in;
    t_reply   w_rply;

    t_request r_req;
    t_request n_req;
    logic     r_s1_valid;
    logic     n_s1_valid;
    t_reply   r_rply;
    t_reply   n_rply;
    logic     r_out_valid;
    logic     n_out_valid;

    logic     w_s2_ready;
    logic     w_s1_ready;
    logic     w_in_xfer;
    logic     w_s2_load;

    nsrb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    nsrb_calc u_calc (
        .i_req  (r_req),
        .i_cfg  (w_cfg),
        .o_rply (w_rply)
    );

    assign w_req_in.request_flags       = s_axis_tdata[7:0];
    assign w_req_in.request_transmit_ts = s_axis_tdata[71:8];
    assign w_req_in.client_address      = s_axis_tdata[103:72];
    assign w_req_in.now_seconds         = s_axis_tdata[135:104];
    assign w_req_in.now_microseconds    = s_axis_tdata[155:136];

    assign w_s2_ready    = !r_out_valid || m_axis_tready;
    assign w_s1_ready    = !r_s1_valid || w_s2_ready;
    assign w_in_xfer     = s_axis_tvalid && w_s1_ready;
    assign w_s2_load     = r_s1_valid && w_s2_ready;
    assign s_axis_tready = w_s1_ready;

    always_comb begin
        n_req       = w_in_xfer ? w_req_in : r_req;
        n_s1_valid  = w_in_xfer || (r_s1_valid && !w_s2_ready);
        n_rply      = w_s2_load ? w_rply : r_rply;
        n_out_valid = w_s2_load || (r_out_valid && !m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_rply <= n_rply;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_rply.status;
    assign m_axis_tdata  = {3'd0, r_rply.applied_offset, r_rply.reply_ts,
                            r_rply.origin_ts, r_rply.reply_flags};

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rply.status != ST_REPLY) |->
        (r_rply.reply_flags == 8'd0 && r_rply.origin_ts == 64'd0 &&
         r_rply.reply_ts == 64'd0 && r_rply.applied_offset == '0))
        else $error("dropped request carries nonzero result fields");

    a_reply_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rply.status == ST_REPLY) |->
        (r_rply.reply_flags[2:0] == MODE_SERVER && r_rply.reply_flags[7:6] == 2'b00))
        else $error("reply flags lack server mode or leap bits are set");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_ready) |=> (r_s1_valid && $stable(r_req)))
        else $error("stalled request lost from input stage");

    a_s1_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s2_ready) |=> r_out_valid)
        else $error("request left input stage without reaching output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule

[rtl/core/nsrb_cfg.sv]
// ----------------------------------------------------------------------------
// nsrb_cfg
// APB register file: maximum offset and obfuscation enable.
// ----------------------------------------------------------------------------
module nsrb_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready,
    output nsrb_pkg::t_cfg      o_cfg
);
    import nsrb_pkg::*;

    logic [OFFSET_BITS-1:0] r_max_offset;
    logic [OFFSET_BITS-1:0] n_max_offset;
    logic                   r_obfuscate;
    logic                   n_obfuscate;
    logic                   w_wr;
    t_reg_index             w_index;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_index  = t_reg_index'(i_paddr[2]);
    assign o_pready = 1'b1;

    always_comb begin
        n_max_offset = r_max_offset;
        n_obfuscate  = r_obfuscate;
        if (w_wr) begin
            case (w_index)
                REG_MAX_OFFSET: n_max_offset = i_pwdata[OFFSET_BITS-1:0];
                REG_OBFUSCATE:  n_obfuscate  = i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_offset <= RST_MAX_OFFSET[OFFSET_BITS-1:0];
            r_obfuscate  <= RST_OBFUSCATE;
        end else begin
            r_max_offset <= n_max_offset;
            r_obfuscate  <= n_obfuscate;
        end
    end

    always_comb begin
        case (w_index)
            REG_MAX_OFFSET: o_prdata = {{(32-OFFSET_BITS){1'b0}}, r_max_offset};
            REG_OBFUSCATE:  o_prdata = {31'd0, r_obfuscate};
            default:        o_prdata = 32'd0;
        endcase
    end

    assign o_cfg.max_offset       = r_max_offset;
    assign o_cfg.obfuscate_enable = r_obfuscate;

endmodule

[rtl/core/nsrb_calc.sv]
// ----------------------------------------------------------------------------
// nsrb_calc
// Request check, client hash and offset, NTP seconds and fraction.
// ----------------------------------------------------------------------------
module nsrb_calc (
    input  nsrb_pkg::t_request  i_req,
    input  nsrb_pkg::t_cfg      i_cfg,
    output nsrb_pkg::t_reply    o_rply
);
    import nsrb_pkg::*;

    logic [2:0]             w_version;
    logic [2:0]             w_mode;
    logic [31:0]            w_addr;
    logic [HASH_BITS-1:0]   w_hash;
    logic [31:0]            w_prod;
    logic [OFFSET_BITS-1:0] w_offset;
    logic [19:0]            w_usec;
    logic [30:0]            w_usec_mul;
    logic [31:0]            w_fraction;
    logic [31:0]            w_seconds;

    assign w_version = i_req.request_flags[5:3];
    assign w_mode    = i_req.request_flags[2:0];
    assign w_addr    = i_req.client_address;

    // xor of address shifted right 24, 15, 6 and left 3, low 11 bits
    assign w_hash = {3'd0, w_addr[31:24]} ^ w_addr[25:15] ^ w_addr[16:6]
                  ^ {w_addr[7:0], 3'd0};

    assign w_prod   = {{(32-OFFSET_BITS){1'b0}}, i_cfg.max_offset}
                    * {{(32-HASH_BITS){1'b0}}, w_hash};
    assign w_offset = i_cfg.obfuscate_enable ? w_prod[31:HASH_BITS]
                                             : {OFFSET_BITS{1'b0}};

    assign w_usec     = i_req.now_microseconds;
    assign w_usec_mul = {11'd0, w_usec} * 31'd1825;
    assign w_fraction = {w_usec, 12'd0} + {4'd0, w_usec, 8'd0}
                      - {6'd0, w_usec_mul[30:5]};

    assign w_seconds = i_req.now_seconds + UNIX_TO_NTP_SECONDS
                     - {{(32-OFFSET_BITS){1'b0}}, w_offset};

    always_comb begin
        o_rply = '0;
        if (w_version < VERSION_MIN_OK) begin
            o_rply.status = ST_BAD_VERSION;
        end else if (w_mode != MODE_CLIENT) begin
            o_rply.status = ST_NOT_CLIENT;
        end else begin
            o_rply.status         = ST_REPLY;
            o_rply.reply_flags    = {2'b00, i_req.request_flags[5:3], MODE_SERVER};
            o_rply.origin_ts      = i_req.request_transmit_ts;
            o_rply.reply_ts       = {w_seconds, w_fraction};
            o_rply.applied_offset = w_offset;
        end
    end

endmodule
